// ===== rtl/lrt_pkg.sv =====
package lrt_pkg;

  localparam int NUM_SETS_DEF = 64;
  localparam int NUM_WAYS_DEF = 8;

  localparam int SET_IDX_W = 6;
  localparam int WAY_IDX_W = 3;
  localparam int WIU_W     = 4;
  localparam int COUNT_W   = 4;

  localparam logic [WIU_W-1:0] WIU_RESET = 4'd8;

  localparam logic FUNC_TOUCH = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way_index;
  } lrt_in_t;

  typedef struct packed {
    logic [WAY_IDX_W-1:0] victim_way;
    logic                 way_was_tracked;
    logic [COUNT_W-1:0]   tracked_count;
  } lrt_out_t;

endpackage

// ===== rtl/lrt_core.sv =====
module lrt_core import lrt_pkg::*; #(
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  localparam int WAY_W = $clog2(NUM_WAYS),
  localparam int CNT_W = $clog2(NUM_WAYS + 1)
) (
  input  logic                            func,
  input  logic [WAY_IDX_W-1:0]            way,
  input  logic [WIU_W-1:0]                ways_in_use,
  input  logic [CNT_W-1:0]                cnt,
  input  logic [NUM_WAYS-1:0][WAY_W-1:0]  order,
  output logic                            wr_en,
  output logic [CNT_W-1:0]                cnt_next,
  output logic [NUM_WAYS-1:0][WAY_W-1:0]  order_next,
  output lrt_out_t                        res
);

  logic                 way_ok;
  logic [WAY_W-1:0]     way_w;
  logic [CNT_W-1:0]     lim;
  logic [NUM_WAYS-1:0]  hit;
  logic [NUM_WAYS-1:0]  shift;
  logic [NUM_WAYS-1:0]  used;
  logic                 found;
  logic                 seen;
  logic                 full;
  logic                 free_found;
  logic [WAY_W-1:0]     free_way;
  logic [WAY_W-1:0]     lru_way;
  logic [WAY_W-1:0]     victim;

  always_comb begin
    way_ok = 32'(way) < NUM_WAYS;
    way_w  = WAY_W'(way);
    lim    = (32'(ways_in_use) > NUM_WAYS) ? CNT_W'(NUM_WAYS) : CNT_W'(ways_in_use);

    for (int i = 0; i < NUM_WAYS; i++) begin
      hit[i] = (CNT_W'(i) < cnt) && (order[i] == way_w);
    end
    found = |hit;

    // entries at or before the hit position (or the tail when new) move down by one
    seen = 1'b0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      shift[i] = !seen && (found || (CNT_W'(i) <= cnt));
      seen     = seen | hit[i];
    end

    full  = !found && (cnt >= CNT_W'(NUM_WAYS));
    wr_en = (func == FUNC_TOUCH) && way_ok && !full;

    order_next[0] = way_w;
    for (int i = 1; i < NUM_WAYS; i++) begin
      order_next[i] = shift[i] ? order[i-1] : order[i];
    end
    cnt_next = (wr_en && !found) ? cnt + 1'b1 : cnt;

    for (int w = 0; w < NUM_WAYS; w++) begin
      used[w] = 1'b0;
      for (int i = 0; i < NUM_WAYS; i++) begin
        used[w] = used[w] | ((CNT_W'(i) < cnt) && (order[i] == WAY_W'(w)));
      end
    end

    // lowest way below the limit that is not tracked
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!free_found && !used[w] && (CNT_W'(w) < lim)) begin
        free_way   = WAY_W'(w);
        free_found = 1'b1;
      end
    end

    lru_way = order[WAY_W'(cnt - 1'b1)];

    if (cnt == '0) begin
      victim = '0;
    end else if ((cnt < lim) && free_found) begin
      victim = free_way;
    end else begin
      victim = lru_way;
    end

    res.victim_way      = (func == FUNC_QUERY) ? WAY_IDX_W'(victim) : '0;
    res.way_was_tracked = (func == FUNC_TOUCH) && way_ok && found;
    res.tracked_count   = COUNT_W'(cnt_next);
  end

endmodule

// ===== rtl/lru_replacement_tracker.sv =====
// true lru tracker: per set recency order plus tracked count, kept in one row memory
// a request is read into the update stage, then its result is registered onto out_data
// throughput: one request per cycle unless held; the row read, update and write-back
//   are pipelined with a forward path for back-to-back requests to the same set
// reset: counts read as zero through per-set valid bits, ways_in_use returns to 8,
//   no clearing pass, requests are taken from the first cycle after reset
module lru_replacement_tracker import lrt_pkg::*; #(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int NUM_WAYS = NUM_WAYS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIU_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  lrt_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lrt_out_t         out_data
);

  localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int CNT_W  = $clog2(NUM_WAYS + 1);
  localparam int ORD_W  = NUM_WAYS * WAY_W;
  localparam int ROW_W  = CNT_W + ORD_W;
  localparam int SET_IN = 2 ** SET_IDX_W;

  logic [WIU_W-1:0]  ways_in_use;

  logic [SET_AW-1:0] set_map [SET_IN];
  logic [SET_AW-1:0] in_set;

  logic [ROW_W-1:0]  mem [NUM_SETS];
  logic [ROW_W-1:0]  rd_row;
  logic [NUM_SETS-1:0] set_vld;

  logic                 s1_valid;
  logic                 s1_func;
  logic [SET_AW-1:0]    s1_set;
  logic [WAY_IDX_W-1:0] s1_way;
  logic                 byp;
  logic [ROW_W-1:0]     byp_row;

  logic              in_fire;
  logic              s1_adv;
  logic              wr_fire;
  logic [ROW_W-1:0]  cur_row;
  logic [CNT_W-1:0]  cnt_eff;
  logic [ROW_W-1:0]  wr_row;

  logic                           core_wr_en;
  logic [CNT_W-1:0]               core_cnt_next;
  logic [NUM_WAYS-1:0][WAY_W-1:0] core_order;
  logic [NUM_WAYS-1:0][WAY_W-1:0] core_order_next;
  lrt_out_t                       core_res;

  // set index wraps modulo the number of sets
  for (genvar v = 0; v < SET_IN; v++) begin : g_set_map
    assign set_map[v] = SET_AW'(v % NUM_SETS);
  end
  assign in_set = set_map[in_data.set_index];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= WIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ways_in_use <= cfg_data;
    end
  end

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_fire  = s1_valid && s1_adv && core_wr_en;

  assign cur_row    = byp ? byp_row : rd_row;
  assign cnt_eff    = (byp || set_vld[s1_set]) ? cur_row[ROW_W-1:ORD_W] : '0;
  assign core_order = cur_row[ORD_W-1:0];
  assign wr_row     = {core_cnt_next, core_order_next};

  lrt_core #(
    .NUM_WAYS(NUM_WAYS)
  ) u_core (
    .func       (s1_func),
    .way        (s1_way),
    .ways_in_use(ways_in_use),
    .cnt        (cnt_eff),
    .order      (core_order),
    .wr_en      (core_wr_en),
    .cnt_next   (core_cnt_next),
    .order_next (core_order_next),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_row <= mem[in_set];
    end
    if (wr_fire) begin
      mem[s1_set] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_vld <= '0;
    end else if (wr_fire) begin
      set_vld[s1_set] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp      <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
      // the row read this edge misses the write-back of the same edge
      byp      <= in_fire && wr_fire && (s1_set == in_set);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func <= in_data.func;
      s1_set  <= in_set;
      s1_way  <= in_data.way_index;
      byp_row <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_data <= core_res;
    end
  end

  a_byp_needs_item: assert property (@(posedge clk) disable iff (rst)
    byp |-> s1_valid)
    else $error("forward flag set without an item in the update stage");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (32'(core_cnt_next) <= NUM_WAYS))
    else $error("tracked count exceeds the number of ways");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_func == FUNC_TOUCH) && core_res.way_was_tracked)
      |-> (core_cnt_next == cnt_eff))
    else $error("touch of a tracked way changed the count");

endmodule

// ===== tb/sv/tb_lru_replacement_tracker.sv =====
`timescale 1ns / 1ps

module tb_lru_replacement_tracker;
  import lrt_pkg::*;

  class lru_shadow;
    logic [WAY_IDX_W-1:0] order [NUM_SETS_DEF][NUM_WAYS_DEF];
    logic [COUNT_W-1:0]   tracked [NUM_SETS_DEF];
    logic [WIU_W-1:0]     ways_limit;
    lrt_out_t             due_results[$];
    int errors;
    int touches;
    int queries;
    int checked;
    int limit_writes;

    function new();
      foreach (order[s, i]) order[s][i] = '0;
      foreach (tracked[s]) tracked[s] = '0;
      ways_limit   = WIU_RESET;
      errors       = 0;
      touches      = 0;
      queries      = 0;
      checked      = 0;
      limit_writes = 0;
    endfunction

    function void set_ways(logic [WIU_W-1:0] v);
      ways_limit = v;
      limit_writes++;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function logic [WAY_IDX_W-1:0] pick_victim(int s);
      int  cnt;
      int  lim;
      bit  used;
      cnt = int'(tracked[s]);
      lim = (ways_limit > NUM_WAYS_DEF) ? NUM_WAYS_DEF : int'(ways_limit);
      if (cnt == 0) return '0;
      // free way search stays below the configured limit
      if (cnt < lim) begin
        for (int w = 0; w < lim; w++) begin
          used = 1'b0;
          for (int i = 0; i < cnt; i++) begin
            if (order[s][i] == w) used = 1'b1;
          end
          if (!used) return WAY_IDX_W'(w);
        end
      end
      return order[s][cnt-1];
    endfunction

    function void note_request(lrt_in_t r);
      lrt_out_t e;
      int       s;
      int       cnt;
      int       pos;
      e = '0;
      s = int'(r.set_index);
      if (r.func == FUNC_TOUCH) begin
        touches++;
        cnt = int'(tracked[s]);
        pos = cnt;
        for (int i = 0; i < cnt; i++) begin
          if (pos == cnt && order[s][i] == r.way_index) pos = i;
        end
        if (pos < cnt) begin
          e.way_was_tracked = 1'b1;
        end else if (cnt < NUM_WAYS_DEF) begin
          tracked[s] = COUNT_W'(cnt + 1);
        end
        if (pos < cnt || cnt < NUM_WAYS_DEF) begin
          for (int i = pos; i > 0; i--) order[s][i] = order[s][i-1];
          order[s][0] = r.way_index;
        end
      end else begin
        queries++;
        e.victim_way = pick_victim(s);
      end
      e.tracked_count = tracked[s];
      due_results.push_back(e);
    endfunction

    function void check_result(lrt_out_t got);
      lrt_out_t e;
      if (due_results.size() == 0) begin
        $error("result with no request waiting: %p", got);
        errors++;
        return;
      end
      e = due_results.pop_front();
      checked++;
      if (got.victim_way !== e.victim_way) begin
        $error("victim_way: expected %0d, got %0d", e.victim_way, got.victim_way);
        errors++;
      end
      if (got.way_was_tracked !== e.way_was_tracked) begin
        $error("way_was_tracked: expected %0d, got %0d", e.way_was_tracked,
               got.way_was_tracked);
        errors++;
      end
      if (got.tracked_count !== e.tracked_count) begin
        $error("tracked_count: expected %0d, got %0d", e.tracked_count, got.tracked_count);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [WIU_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  lrt_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  lrt_out_t         out_data;
  logic             hold_go;

  lru_shadow board = new();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lru_replacement_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // requests are noted before results are checked within the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_ways(cfg_data);
      if (in_valid && in_ready) board.note_request(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  initial begin
    int  len;
    int  mode;
    bit  hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 40);
      repeat (len) begin
        @(posedge clk);
        if (hold_go && !hold_done) begin
          // long hold-off so the pipeline backs up into in_ready
          out_ready <= 1'b0;
          hold_done = 1'b1;
          repeat (80) @(posedge clk);
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 0);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_request(input logic f, input logic [SET_IDX_W-1:0] s,
                              input logic [WAY_IDX_W-1:0] w);
    lrt_in_t r;
    r.func      = f;
    r.set_index = s;
    r.way_index = w;
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ways(input logic [WIU_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input bit steady);
    logic [SET_IDX_W-1:0] pool [4];
    logic                 f;
    logic [SET_IDX_W-1:0] s;
    logic [WAY_IDX_W-1:0] w;
    int                   burst;
    int                   lim;
    foreach (pool[k]) pool[k] = SET_IDX_W'($urandom_range(0, NUM_SETS_DEF - 1));
    lim = int'(board.ways_limit);
    if (lim < 1) lim = 1;
    if (lim > NUM_WAYS_DEF) lim = NUM_WAYS_DEF;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(0, 9) < 3) ? FUNC_QUERY : FUNC_TOUCH;
      // a few hot sets so orders fill and wrap; now and then any set
      s = ($urandom_range(0, 6) != 0) ? pool[$urandom_range(0, 3)]
                                      : SET_IDX_W'($urandom_range(0, NUM_SETS_DEF - 1));
      w = ($urandom_range(0, 3) != 0) ? WAY_IDX_W'($urandom_range(0, lim - 1))
                                      : WAY_IDX_W'($urandom_range(0, NUM_WAYS_DEF - 1));
      send_request(f, s, w);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if (!steady && $urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    logic [WIU_W-1:0] limits [12];
    limits = '{4'd15, 4'd1, 4'd8, 4'd3, 4'd0, 4'd5, 4'd9, 4'd2, 4'd7, 4'd4, 4'd6, 4'd8};
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_go   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // untouched sets, first fills, retouch, full set and its lru
    send_request(FUNC_QUERY, 6'd0, 3'd0);
    send_request(FUNC_QUERY, 6'd63, 3'd7);
    send_request(FUNC_TOUCH, 6'd0, 3'd7);
    send_request(FUNC_QUERY, 6'd0, 3'd0);
    send_request(FUNC_TOUCH, 6'd0, 3'd0);
    send_request(FUNC_TOUCH, 6'd0, 3'd7);
    send_request(FUNC_QUERY, 6'd0, 3'd0);
    for (int w = 0; w < NUM_WAYS_DEF; w++) send_request(FUNC_TOUCH, 6'd63, WAY_IDX_W'(w));
    send_request(FUNC_TOUCH, 6'd63, 3'd3);
    send_request(FUNC_QUERY, 6'd63, 3'd0);
    send_request(FUNC_TOUCH, 6'd63, 3'd0);
    send_request(FUNC_QUERY, 6'd63, 3'd5);
    drain_results();

    // more ways tracked than in use, and a way above the limit
    write_ways(4'd2);
    send_request(FUNC_QUERY, 6'd63, 3'd0);
    send_request(FUNC_TOUCH, 6'd1, 3'd5);
    send_request(FUNC_QUERY, 6'd1, 3'd0);
    drain_results();

    // zero ways in use falls back to the lru way
    write_ways(4'd0);
    send_request(FUNC_QUERY, 6'd1, 3'd0);
    send_request(FUNC_QUERY, 6'd2, 3'd0);
    drain_results();

    foreach (limits[p]) begin
      write_ways(limits[p]);
      if (p == 3) hold_go <= 1'b1;
      run_phase(158, p == 3);
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("checked %0d results from %0d touches and %0d victim queries",
             board.checked, board.touches, board.queries);
    $display("ways_in_use written %0d times, from 0 up to 15", board.limit_writes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
